FILE: src/srd_pkg.sv
// Shared types, constants and helper functions for the session record decoder.
// Depends on nothing; srd_parse and the top level refer to it by scoped names.
package srd_pkg;

   localparam logic [31:0] REC_MAGIC      = 32'h5254_5342;
   localparam logic [15:0] REC_VERSION    = 16'h0001;
   localparam logic [15:0] CRC_INIT       = 16'hFFFF;
   localparam logic [15:0] CRC_POLY       = 16'h1021;
   localparam logic [15:0] CRC_TOP        = 16'h8000;
   localparam logic [15:0] REC_FLAG_VALID = 16'h0001;
   localparam logic [7:0]  HEADER_BYTES   = 8'd8;
   localparam logic [7:0]  FIELD_BASE     = 8'd8;
   localparam int          FIELD_COUNT    = 19;
   localparam logic [7:0]  FIELD_END      = 8'd27;
   localparam logic [7:0]  CRC_OFFSET     = 8'd30;
   localparam logic [7:0]  CRC_OFFSET_HI  = 8'd31;
   localparam int          FIELD_IDX_W    = $clog2(FIELD_COUNT);

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_EMPTY   = 2'd1,
      STATUS_INVALID = 2'd2
   } status_type;

   typedef struct packed {
      status_type  status;
      logic        record_valid;
      logic [15:0] secs_left;
      logic [15:0] run_minutes;
      logic [15:0] pause_secs_left;
      logic [31:0] target_pressure;
      logic [31:0] sequence_number;
      logic [7:0]  session_state;
      logic [7:0]  pauses_taken;
      logic [7:0]  pauses_allowed;
   } rsp_word_type;

   // One byte of CRC-16/CCITT-FALSE, MSB first.
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if ((c & CRC_TOP) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   // Expected value of header byte pos (0 to 7); the size word is little-endian.
   function automatic logic [7:0] expected_header(input logic [2:0] pos,
                                                  input logic [15:0] size);
      logic [7:0] e;
      unique case (pos)
         3'd0:    e = REC_MAGIC[7:0];
         3'd1:    e = REC_MAGIC[15:8];
         3'd2:    e = REC_MAGIC[23:16];
         3'd3:    e = REC_MAGIC[31:24];
         3'd4:    e = REC_VERSION[7:0];
         3'd5:    e = REC_VERSION[15:8];
         3'd6:    e = size[7:0];
         default: e = size[15:8];
      endcase
      return e;
   endfunction

endpackage

FILE: src/srd_if.sv
// Valid/ready channel interfaces for the request bytes and the decoded result words.
// Depends on nothing; the payload widths follow the result word type in srd_pkg.
interface srd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_of_record;

   modport source (output valid, output data_byte, output first_of_record, input ready);
   modport sink   (input valid, input data_byte, input first_of_record, output ready);
endinterface

interface srd_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic               record_valid;
   logic [15:0]        secs_left;
   logic [15:0]        run_minutes;
   logic [15:0]        pause_secs_left;
   logic signed [31:0] target_pressure;
   logic [31:0]        sequence_number;
   logic [7:0]         session_state;
   logic [7:0]         pauses_taken;
   logic [7:0]         pauses_allowed;

   modport source (output valid, output status, output record_valid,
                   output secs_left, output run_minutes,
                   output pause_secs_left, output target_pressure,
                   output sequence_number, output session_state,
                   output pauses_taken, output pauses_allowed, input ready);
   modport sink   (input valid, input status, input record_valid,
                   input secs_left, input run_minutes,
                   input pause_secs_left, input target_pressure,
                   input sequence_number, input session_state,
                   input pauses_taken, input pauses_allowed, output ready);
endinterface

FILE: src/srd_parse.sv
// Record parser: byte position, running CRC, header check and field capture.
// Depends on srd_pkg for the CRC and header functions and the result word type.
module srd_parse #(
   parameter int RECORD_BYTES = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           data_byte,
   input  logic                 first_of_record,
   output logic                 last_byte,
   output srd_pkg::rsp_word_type result
);

   localparam int          POS_W     = $clog2(RECORD_BYTES);
   localparam logic [15:0] SIZE_WORD = 16'(RECORD_BYTES);
   localparam logic [7:0]  LAST_POS  = 8'(RECORD_BYTES - 1);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      crc_ff, crc_in;
   logic             header_ff, header_in;
   logic [15:0]      check_ff, check_in;
   logic [7:0]       field_ff [srd_pkg::FIELD_COUNT];

   logic [7:0]                    pos;
   logic [15:0]                   crc_base;
   logic                          header_base;
   logic                          field_we;
   logic [srd_pkg::FIELD_IDX_W-1:0] field_idx;
   logic                          ok;

   always_comb begin
      pos         = first_of_record ? 8'd0 : 8'(pos_ff);
      crc_base    = first_of_record ? srd_pkg::CRC_INIT : crc_ff;
      header_base = first_of_record ? 1'b1 : header_ff;
      last_byte   = (pos == LAST_POS);

      crc_in = (pos < srd_pkg::CRC_OFFSET) ? srd_pkg::crc16_byte(crc_base, data_byte)
                                           : crc_base;
      header_in = header_base;
      if (pos < srd_pkg::HEADER_BYTES) begin
         header_in = header_base && (data_byte == srd_pkg::expected_header(pos[2:0], SIZE_WORD));
      end
      check_in = check_ff;
      if (pos == srd_pkg::CRC_OFFSET) begin
         check_in = {check_ff[15:8], data_byte};
      end else if (pos == srd_pkg::CRC_OFFSET_HI) begin
         check_in = {data_byte, check_ff[7:0]};
      end
      field_we  = (pos >= srd_pkg::FIELD_BASE) && (pos < srd_pkg::FIELD_END);
      field_idx = srd_pkg::FIELD_IDX_W'(pos - srd_pkg::FIELD_BASE);
      pos_in    = last_byte ? '0 : POS_W'(pos + 8'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         crc_ff    <= srd_pkg::CRC_INIT;
         header_ff <= 1'b1;
      end else if (step) begin
         pos_ff    <= pos_in;
         crc_ff    <= last_byte ? srd_pkg::CRC_INIT : crc_in;
         header_ff <= last_byte ? 1'b1 : header_in;
      end
   end

   // The stored check and field bytes are always rewritten before they are read.
   always_ff @(posedge clock) begin
      if (step) begin
         check_ff <= check_in;
         if (field_we) begin
            field_ff[field_idx] <= data_byte;
         end
      end
   end

   // The last byte never falls on a field byte, so the field registers are current.
   always_comb begin
      result = '0;
      ok     = field_ff[0][0] && ({field_ff[3], field_ff[2]} != 16'h0000);
      if (!header_in || (check_in != crc_in)) begin
         result.status = srd_pkg::STATUS_INVALID;
      end else begin
         result.status          = ok ? srd_pkg::STATUS_OK : srd_pkg::STATUS_EMPTY;
         result.record_valid    = ok;
         result.secs_left       = {field_ff[3], field_ff[2]};
         result.run_minutes     = {field_ff[5], field_ff[4]};
         result.pause_secs_left = {field_ff[7], field_ff[6]};
         result.target_pressure = {field_ff[11], field_ff[10], field_ff[9], field_ff[8]};
         result.sequence_number = {field_ff[15], field_ff[14], field_ff[13], field_ff[12]};
         result.session_state   = field_ff[16];
         result.pauses_taken    = field_ff[17];
         result.pauses_allowed  = field_ff[18];
      end
   end

endmodule

FILE: src/session_record_decoder_unit.sv
// Top level of the session record decoder: input byte register, parser, result register.
// Depends on srd_pkg, srd_if.sv (srd_req_if, srd_rsp_if) and srd_parse.
//
// The decoder takes a stored session record one byte per word on the req channel,
// RECORD_BYTES bytes long, multi-byte fields little-endian. It runs CRC-16/CCITT-FALSE
// over bytes 0 to 29, checks the magic word, the version and the size field in bytes
// 0 to 7, and compares the CRC against bytes 30 and 31. After the last byte of a record
// exactly one word appears on the rsp channel: status INVALID with all fields zero on
// any mismatch, EMPTY when bit 0 of the flags word is clear or the remaining seconds
// are zero, otherwise OK with record_valid set. A record follows the previous one
// without any gap, and first_of_record set on a byte drops a partial record and makes
// that byte byte 0. The block accepts one byte every cycle while it is not stalled; a byte
// is held in the input register while the parser consumes it, and on the last byte of a
// record the parser's result is written into the result register, which drives rsp.
// Only a result that is still waiting on rsp while another last byte arrives holds
// the input side.
module session_record_decoder_unit #(
   parameter int RECORD_BYTES = 32
) (
   input logic          clock,
   input logic          reset,
   srd_req_if.sink      req,
   srd_rsp_if.source    rsp
);

   logic       req_valid_ff;
   logic [7:0] req_byte_ff;
   logic       req_first_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   srd_pkg::rsp_word_type rsp_word_ff;

   srd_pkg::rsp_word_type result;
   logic                  last_byte;
   logic                  stall;
   logic                  advance;

   // The parser consumes the registered byte unless it completes a record while the
   // previous result is still held by the consumer.
   assign stall     = req_valid_ff && last_byte && rsp_valid_ff && !rsp.ready;
   assign advance   = req_valid_ff && !stall;
   assign req.ready = !req_valid_ff || advance;

   assign rsp_valid_in = (advance && last_byte) || (rsp_valid_ff && !rsp.ready);

   srd_parse #(
      .RECORD_BYTES(RECORD_BYTES)
   ) u_parse (
      .clock          (clock),
      .reset          (reset),
      .step           (advance),
      .data_byte      (req_byte_ff),
      .first_of_record(req_first_ff),
      .last_byte      (last_byte),
      .result         (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req.ready) begin
            req_valid_ff <= req.valid;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         req_byte_ff  <= req.data_byte;
         req_first_ff <= req.first_of_record;
      end
      if (advance && last_byte) begin
         rsp_word_ff <= result;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.status          = rsp_word_ff.status;
   assign rsp.record_valid    = rsp_word_ff.record_valid;
   assign rsp.secs_left       = rsp_word_ff.secs_left;
   assign rsp.run_minutes     = rsp_word_ff.run_minutes;
   assign rsp.pause_secs_left = rsp_word_ff.pause_secs_left;
   assign rsp.target_pressure = $signed(rsp_word_ff.target_pressure);
   assign rsp.sequence_number = rsp_word_ff.sequence_number;
   assign rsp.session_state   = rsp_word_ff.session_state;
   assign rsp.pauses_taken    = rsp_word_ff.pauses_taken;
   assign rsp.pauses_allowed  = rsp_word_ff.pauses_allowed;

endmodule
